/* design/esd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_DELETE_CODE = '0;
    localparam logic [7:0]           DELETE_CODE_RST = 8'd127;

    // one decoded result as it travels to the output
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_result;

    // what one accepted byte hands to the result queue
    typedef struct packed {
        logic [1:0] push_n;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

`default_nettype wire

/* design/esd_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module esd_regs
    import esd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output logic      [APB_DATA_W-1:0] o_prdata,
    output logic                       o_pready,
    output logic      [7:0]            o_delete_code
);

    logic [7:0]           r_delete_code;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = i_paddr[APB_ADDR_W-1:2];
    assign wr_en   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delete_code <= DELETE_CODE_RST;
        end else if (wr_en && reg_idx == REG_DELETE_CODE) begin
            r_delete_code <= i_pwdata[7:0];
        end
    end

    assign o_prdata      = (reg_idx == REG_DELETE_CODE) ? APB_DATA_W'(r_delete_code) : '0;
    assign o_pready      = 1'b1;
    assign o_delete_code = r_delete_code;

endmodule

`default_nettype wire

/* design/esd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module esd_decode
    import esd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic [7:0] i_delete_code,
    output t_step           o_step
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_CARET  = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_OCT    = 3'd4
    } t_mode;

    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CODE_LF   = 8'd10;
    localparam logic [7:0] CODE_CR   = 8'd13;
    localparam logic [7:0] CODE_TAB  = 8'd9;
    localparam logic [7:0] CODE_BS   = 8'd8;
    localparam logic [7:0] HEX_BIAS  = CH_LOW_A - 8'd10;

    t_mode      r_mode, n_mode;
    logic       r_cnt, n_cnt;
    logic [7:0] r_acc, n_acc;

    logic       is_dig, is_let, digit_ok;
    logic [7:0] hex_d, acc_next;
    logic       nm_emit;
    t_mode      nm_mode;
    logic [1:0] a_n;
    logic [7:0] a0, a1;

    assign is_dig  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_let  = ((i_byte >= CH_LOW_A) && (i_byte <= CH_LOW_Z))
                  || ((i_byte >= CH_UP_A) && (i_byte <= CH_UP_Z));
    // any letter counts as lower case, so upper case wraps modulo 256
    assign hex_d   = is_dig ? (i_byte - CH_ZERO) : (i_byte - HEX_BIAS);
    assign nm_emit = (i_byte != CH_BSL) && (i_byte != CH_CARET);
    assign nm_mode = (i_byte == CH_BSL)   ? MODE_ESC
                   : (i_byte == CH_CARET) ? MODE_CARET : MODE_NORMAL;

    always_comb begin
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        a_n      = 2'd0;
        a0       = 8'h00;
        a1       = 8'h00;
        digit_ok = (r_mode == MODE_HEX) ? (is_dig || is_let) : is_dig;
        acc_next = (r_mode == MODE_HEX) ? ({r_acc[3:0], 4'h0} + hex_d)
                                        : ({r_acc[4:0], 3'b000} + (i_byte - CH_ZERO));
        unique case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_NORMAL;
                priority if (i_byte == CH_N) begin
                    a_n = 2'd1; a0 = CODE_LF;
                end else if (i_byte == CH_R) begin
                    a_n = 2'd1; a0 = CODE_CR;
                end else if (i_byte == CH_T) begin
                    a_n = 2'd1; a0 = CODE_TAB;
                end else if (i_byte == CH_B) begin
                    a_n = 2'd1; a0 = CODE_BS;
                end else if (i_byte == CH_X) begin
                    n_mode = MODE_HEX; n_cnt = 1'b0; n_acc = 8'h00;
                end else if (i_byte == CH_ZERO) begin
                    n_mode = MODE_OCT; n_cnt = 1'b0; n_acc = 8'h00;
                end else begin
                    a_n = 2'd1; a0 = i_byte;
                end
            end
            MODE_CARET: begin
                n_mode = MODE_NORMAL;
                a_n    = 2'd1;
                a0     = (i_byte == CH_QMARK) ? i_delete_code : (i_byte - CH_AT);
            end
            MODE_HEX, MODE_OCT: begin
                if (digit_ok) begin
                    if (r_cnt) begin
                        a_n    = 2'd1;
                        a0     = acc_next;
                        n_mode = MODE_NORMAL;
                        n_cnt  = 1'b0;
                        n_acc  = 8'h00;
                    end else begin
                        n_acc = acc_next;
                        n_cnt = 1'b1;
                    end
                end else begin
                    // pending value goes out, the byte is then plain text
                    a0     = r_acc;
                    a1     = i_byte;
                    a_n    = nm_emit ? 2'd2 : 2'd1;
                    n_mode = nm_mode;
                    n_cnt  = 1'b0;
                    n_acc  = 8'h00;
                end
            end
            default: begin
                n_mode = nm_mode;
                if (nm_emit) begin
                    a_n = 2'd1; a0 = i_byte;
                end
            end
        endcase

        // end of string: flush a pending value, drop a dangling escape
        if (i_last) begin
            if (n_mode == MODE_HEX || n_mode == MODE_OCT) begin
                a_n = 2'd1;
                a0  = n_acc;
            end
            n_mode = MODE_NORMAL;
            n_cnt  = 1'b0;
            n_acc  = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cnt  <= 1'b0;
            r_acc  <= 8'h00;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
        end
    end

    always_comb begin
        o_step.res0.data  = a0;
        o_step.res0.valid = (a_n != 2'd0);
        o_step.res0.last  = i_last && (a_n != 2'd2);
        o_step.res1.data  = a1;
        o_step.res1.valid = 1'b1;
        o_step.res1.last  = i_last;
        if (!i_accept) begin
            o_step.push_n = 2'd0;
        end else if (a_n == 2'd0 && i_last) begin
            o_step.push_n = 2'd1;
        end else begin
            o_step.push_n = a_n;
        end
    end

endmodule

`default_nettype wire

/* design/esd_outq.sv */
`timescale 1ns / 1ps
`default_nettype none

module esd_outq
    import esd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_step i_step,
    input  wire logic  i_pop,
    output logic       o_ready,
    output logic       o_valid,
    output t_result    o_head
);

    localparam int DEPTH = 3;

    t_result    r_q [DEPTH];
    t_result    n_q [DEPTH];
    t_result    sh  [DEPTH];
    logic [1:0] r_cnt, n_cnt, cp;

    // head slot feeds the port, entries shift down on a pop
    always_comb begin
        sh[0] = i_pop ? r_q[1] : r_q[0];
        sh[1] = i_pop ? r_q[2] : r_q[1];
        sh[2] = r_q[2];
        cp    = r_cnt - 2'(i_pop);
        for (int j = 0; j < DEPTH; j++) begin
            if (2'(j) < cp) begin
                n_q[j] = sh[j];
            end else if (2'(j) == cp && i_step.push_n != 2'd0) begin
                n_q[j] = i_step.res0;
            end else if (2'(j) == 2'(cp + 2'd1) && i_step.push_n == 2'd2) begin
                n_q[j] = i_step.res1;
            end else begin
                n_q[j] = sh[j];
            end
        end
        n_cnt = cp + i_step.push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

    // room for two results, independent of the output side this cycle
    assign o_ready = (r_cnt <= 2'd1);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[0];

endmodule

`default_nettype wire

/* design/escape_sequence_decoder_core.sv */
// channel      | direction | payload
// s_axis       | in        | tdata: in_byte[7:0]; tlast: in_last
// m_axis       | out       | tdata: out_byte[7:0]; tuser: out_valid; tlast: out_last
// apb          | in/out    | reg 0 at 0x0: delete_code[7:0], reset 127
//
// one input byte is taken per cycle while s_axis_tready is high; the state update
// is a single pass of logic; each byte gives one or two results (or none); the
// output sends one per cycle while m_axis_tready is high
// a three-entry result queue stands between the sides; s_axis_tready is high
// while it holds at most one result, so an output stall stops input once two wait
// reset is synchronous, active low, and empties the queue at once
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_core
    import esd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [7:0]            i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic                  i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [7:0]            o_m_axis_tdata,   // [7:0] out_byte
    output logic                       o_m_axis_tuser,   // [0] out_valid
    output logic                       o_m_axis_tlast,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output logic      [APB_DATA_W-1:0] o_prdata,
    output logic                       o_pready
);

    logic [7:0] delete_code_q;
    logic       in_accept;
    t_step      step;
    t_result    head;

    esd_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (i_psel),
        .i_penable     (i_penable),
        .i_pwrite      (i_pwrite),
        .i_paddr       (i_paddr),
        .i_pwdata      (i_pwdata),
        .o_prdata      (o_prdata),
        .o_pready      (o_pready),
        .o_delete_code (delete_code_q)
    );

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    esd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_byte        (i_s_axis_tdata),
        .i_last        (i_s_axis_tlast),
        .i_delete_code (delete_code_q),
        .o_step        (step)
    );

    esd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pop   (o_m_axis_tvalid && i_m_axis_tready),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head)
    );

    assign o_m_axis_tdata = head.data;
    assign o_m_axis_tuser = head.valid;
    assign o_m_axis_tlast = head.last;

endmodule

`default_nettype wire

/* design/esd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module esd_checker
    import esd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  o_s_axis_tready,
    input  wire logic                  o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    input  wire logic [7:0]            o_m_axis_tdata,
    input  wire logic                  o_m_axis_tuser,
    input  wire logic                  o_m_axis_tlast,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    input  wire logic [APB_DATA_W-1:0] o_prdata
);

    // nothing is left in the result queue after reset, and input is open
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("result pending or input blocked right after reset");

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output request dropped while stalled");

    // an empty result only marks the end of a string
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast && o_m_axis_tdata == 8'h00)
        else $error("empty result without end mark");

    // a written delete code reads back
    a_cfg_readback: assert property (@(posedge i_clk)
        i_rst_n && i_psel && i_penable && i_pwrite
            && i_paddr[APB_ADDR_W-1:2] == REG_DELETE_CODE
        |=> !i_rst_n || i_paddr[APB_ADDR_W-1:2] != REG_DELETE_CODE
            || o_prdata == APB_DATA_W'($past(i_pwdata[7:0])))
        else $error("delete code readback mismatch");

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .i_psel          (i_psel),
    .i_penable       (i_penable),
    .i_pwrite        (i_pwrite),
    .i_paddr         (i_paddr),
    .i_pwdata        (i_pwdata),
    .o_prdata        (o_prdata)
);

`default_nettype wire

/* dv/esd_result_checker.sv */
`timescale 1ns / 1ps

module esd_result_checker
    import esd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [7:0]            i_s_tdata,
    input  wire logic                  i_s_tlast,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [7:0]            i_m_tdata,
    input  wire logic                  i_m_tuser,
    input  wire logic                  i_m_tlast,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef enum logic [2:0] {
        MD_TEXT   = 3'd0,
        MD_ESCAPE = 3'd1,
        MD_CARET  = 3'd2,
        MD_HEX    = 3'd3,
        MD_OCTAL  = 3'd4
    } t_decode_mode;

    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_CARET  = "^";
    localparam logic [7:0] CH_QUEST  = "?";
    localparam logic [7:0] CH_AT     = "@";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_A_LOW  = "a";
    localparam logic [7:0] CH_Z_LOW  = "z";
    localparam logic [7:0] CH_A_UP   = "A";
    localparam logic [7:0] CH_Z_UP   = "Z";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_R      = "r";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_B      = "b";
    localparam logic [7:0] CH_X      = "x";
    localparam logic [7:0] CODE_LF   = 8'd10;
    localparam logic [7:0] CODE_CR   = 8'd13;
    localparam logic [7:0] CODE_TAB  = 8'd9;
    localparam logic [7:0] CODE_BS   = 8'd8;

    t_decode_mode mode;
    logic [1:0]   digits;
    logic [7:0]   accum;
    logic [7:0]   del_code;
    logic [7:0]   step_bytes [2];
    int           step_n;
    t_result      expected_q [$];
    int           fail_total;

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= CH_A_LOW && c <= CH_Z_LOW) || (c >= CH_A_UP && c <= CH_Z_UP);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        if (step_n < 2) begin
            step_bytes[step_n] = b;
            step_n++;
        end
    endtask

    task automatic text_byte(input logic [7:0] c);
        if (c == CH_BSL) begin
            mode = MD_ESCAPE;
        end else if (c == CH_CARET) begin
            mode = MD_CARET;
        end else begin
            push_byte(c);
        end
    endtask

    task automatic close_value();
        push_byte(accum);
        mode   = MD_TEXT;
        digits = '0;
        accum  = '0;
    endtask

    // works out the decoded bytes for one accepted request and queues them
    task automatic decode_byte(input logic [7:0] c, input logic last);
        logic [7:0] d;
        t_result    r;
        step_n = 0;
        case (mode)
            MD_ESCAPE: begin
                mode = MD_TEXT;
                case (c)
                    CH_N: push_byte(CODE_LF);
                    CH_R: push_byte(CODE_CR);
                    CH_T: push_byte(CODE_TAB);
                    CH_B: push_byte(CODE_BS);
                    CH_X: begin
                        mode   = MD_HEX;
                        digits = '0;
                        accum  = '0;
                    end
                    CH_ZERO: begin
                        mode   = MD_OCTAL;
                        digits = '0;
                        accum  = '0;
                    end
                    default: push_byte(c);
                endcase
            end
            MD_CARET: begin
                mode = MD_TEXT;
                push_byte((c == CH_QUEST) ? del_code : c - CH_AT);
            end
            MD_HEX: begin
                if (is_dec(c) || is_alpha(c)) begin
                    // any letter counts, upper case wraps around below zero
                    d      = is_dec(c) ? c - CH_ZERO : c - CH_A_LOW + 8'd10;
                    accum  = {accum[3:0], 4'h0} + d;
                    digits = digits + 2'd1;
                    if (digits >= 2'd2) close_value();
                end else begin
                    close_value();
                    text_byte(c);
                end
            end
            MD_OCTAL: begin
                if (is_dec(c)) begin
                    accum  = {accum[4:0], 3'b000} + (c - CH_ZERO);
                    digits = digits + 2'd1;
                    if (digits >= 2'd2) close_value();
                end else begin
                    close_value();
                    text_byte(c);
                end
            end
            default: begin
                mode = MD_TEXT;
                text_byte(c);
            end
        endcase

        if (last) begin
            if (mode == MD_HEX || mode == MD_OCTAL) push_byte(accum);
            mode   = MD_TEXT;
            digits = '0;
            accum  = '0;
        end

        for (int k = 0; k < step_n; k++) begin
            r.data  = step_bytes[k];
            r.valid = 1'b1;
            r.last  = last && (k == step_n - 1);
            expected_q.push_back(r);
        end
        // end of string with nothing decoded still gets a marker
        if (last && step_n == 0) begin
            r.data  = 8'h00;
            r.valid = 1'b0;
            r.last  = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_total++;
    endtask

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            mode     = MD_TEXT;
            digits   = '0;
            accum    = '0;
            del_code = DELETE_CODE_RST;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[APB_ADDR_W-1:2] == REG_DELETE_CODE) begin
                del_code = i_pwdata[7:0];
            end
            if (i_s_tvalid && i_s_tready) decode_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", i_m_tdata, 8'h00);
                end else begin
                    want = expected_q.pop_front();
                    if (i_m_tdata != want.data) report_mismatch("data", i_m_tdata, want.data);
                    if (i_m_tuser != want.valid) begin
                        report_mismatch("valid", {7'd0, i_m_tuser}, {7'd0, want.valid});
                    end
                    if (i_m_tlast != want.last) begin
                        report_mismatch("last", {7'd0, i_m_tlast}, {7'd0, want.last});
                    end
                end
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench
    import esd_pkg::*;
();

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 320;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_CARET = "^";
    localparam logic [7:0] CH_QUEST = "?";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_A_LOW = "a";
    localparam logic [7:0] CH_A_UP  = "A";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_N     = "n";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_B     = "b";

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;

    logic                  s_tready;
    logic                  m_tvalid;
    logic [7:0]            m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    int                    idle_cycles = 0;
    bit                    hold_req = 1'b0;
    bit                    s_calm = 1'b0;
    bit                    m_calm = 1'b0;
    logic [7:0]            text_q [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    escape_sequence_decoder_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] in_byte
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [7:0] out_byte
        .o_m_axis_tuser  (m_tuser),    // [0] out_valid
        .o_m_axis_tlast  (m_tlast),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    esd_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_alnum();
        case ($urandom_range(0, 2))
            0:       return 8'(CH_ZERO + $urandom_range(0, 9));
            1:       return 8'(CH_A_LOW + $urandom_range(0, 25));
            default: return 8'(CH_A_UP + $urandom_range(0, 25));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = pick_gap(s_calm);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    // lets the block go quiet before touching the register
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_delete_code(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DELETE_CODE, 2'b00};
        pwdata  <= {{(APB_DATA_W-8){1'b0}}, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random strings built mostly from escape and caret sequences
    task automatic run_strings(input int n_items, input bit with_hold);
        int sent;
        int n_tokens;
        sent = 0;
        while (sent < n_items) begin
            text_q.delete();
            n_tokens = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
            repeat (n_tokens) begin
                case ($urandom_range(0, 9))
                    0, 1: text_q.push_back(8'($urandom_range(0, 255)));
                    2: begin
                        text_q.push_back(CH_BSL);
                        case ($urandom_range(0, 3))
                            0:       text_q.push_back(CH_N);
                            1:       text_q.push_back(CH_R);
                            2:       text_q.push_back(CH_T);
                            default: text_q.push_back(CH_B);
                        endcase
                    end
                    3, 4: begin
                        text_q.push_back(CH_BSL);
                        text_q.push_back(CH_X);
                        repeat ($urandom_range(0, 3)) text_q.push_back(pick_alnum());
                    end
                    5, 6: begin
                        text_q.push_back(CH_BSL);
                        text_q.push_back(CH_ZERO);
                        repeat ($urandom_range(0, 3))
                            text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                    end
                    7: begin
                        text_q.push_back(CH_CARET);
                        text_q.push_back(($urandom_range(0, 2) == 0) ? CH_QUEST
                                                                  : 8'($urandom_range(0, 255)));
                    end
                    8: repeat ($urandom_range(1, 4))
                        text_q.push_back(8'($urandom_range(32, 126)));
                    default: begin
                        text_q.push_back(CH_BSL);
                        text_q.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            s_calm = ($urandom_range(0, 3) == 0);
            foreach (text_q[i]) begin
                if (with_hold && sent == n_items / 2) hold_req = 1'b1;
                send_byte(text_q[i], i == text_q.size() - 1);
                sent++;
            end
        end
    endtask

    // output side: random stalls plus one long hold-off on request
    initial begin : sink
        int unsigned gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 7) == 0) m_calm = !m_calm;
                gap = pick_gap(m_calm);
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_delete_code(8'h00);
        send_text("\\n\\r\\t\\b");
        send_text("\\x4Z\\017");
        send_text("\\x-^?^");
        send_text("\\09\\");
        send_byte(8'h00, 1'b0);
        send_byte(CH_CARET, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("\\xa");
        drain_results();

        write_delete_code(8'hFF);
        run_strings(PHASE_ITEMS, 1'b0);
        drain_results();
        write_delete_code(8'($urandom_range(0, 255)));
        run_strings(PHASE_ITEMS, 1'b1);
        drain_results();
        write_delete_code(8'($urandom_range(1, 254)));
        run_strings(PHASE_ITEMS, 1'b0);
        drain_results();
        write_delete_code(DELETE_CODE_RST);
        run_strings(PHASE_ITEMS, 1'b0);

        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* escape_sequence_decoder_core.f */
design/esd_pkg.sv
design/esd_regs.sv
design/esd_decode.sv
design/esd_outq.sv
design/escape_sequence_decoder_core.sv
design/esd_checker.sv
dv/esd_result_checker.sv
dv/testbench.sv
